// File: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types, constants and the bus phase decoder.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int PHASE_COUNT_WIDTH_DEFAULT = 16;
   localparam int PHASE_TICKS_WIDTH = 16;
   localparam int RETRY_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int REQ_TUSER_WIDTH = 3;
   localparam int REQ_TDATA_WIDTH = 24;
   localparam int RSP_TDATA_WIDTH = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PHASE_TICKS_WIDTH-1:0] PHASE_TICKS_RESET = 16'd100;
   localparam logic [RETRY_WIDTH-1:0] RETRY_LIMIT_RESET = 3'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASE_TICKS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_LIMIT = 1'd1;

   typedef enum logic [2:0] {
      FUNC_NONE  = 3'd0,
      FUNC_START = 3'd1,
      FUNC_WRITE = 3'd2,
      FUNC_READ  = 3'd3,
      FUNC_STOP  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_WBIT   = 3'd1,
      KIND_ACKIN  = 3'd2,
      KIND_STOP   = 3'd3,
      KIND_REL    = 3'd4,
      KIND_RBIT   = 3'd5,
      KIND_ACKOUT = 3'd6,
      KIND_END    = 3'd7
   } kind_type;

   // Classified input item as it travels through the queue.
   typedef struct packed {
      func_type   cmd;
      logic       has_cmd;
      logic       any_func;
      logic [7:0] load_byte;
      logic       end_flag;
      logic       sda;
   } item_type;

   typedef struct packed {
      logic [PHASE_TICKS_WIDTH-1:0] phase_ticks;
      logic [RETRY_WIDTH-1:0]       retry_limit;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] sub;
      logic [2:0] idx;
   } phase_type;

   // Result word, fields listed from the top bit down.
   typedef struct packed {
      logic       pad;
      logic       cmd_rejected;
      logic [7:0] recent_bits;
      logic [7:0] read_byte_out;
      logic       acked;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       sda_level;
      logic       scl_level;
   } rsp_type;

   // Maps a step of a command to its phase kind, the phase within a bit (0..2)
   // and the bit index. Offsets within a segment stay below 32, so the divide
   // by three is a multiply by 11 and a shift by 5.
   function automatic phase_type decode(func_type cmd, logic [5:0] step, logic end_flag);
      phase_type  ph;
      kind_type   kind;
      logic [5:0] base;
      logic [5:0] rel;
      logic [8:0] prod;
      logic [3:0] quo;
      logic [4:0] rem;
      kind = KIND_END;
      base = 6'd0;
      case (cmd)
         FUNC_START: begin
            if (step < 6'd3) begin
               kind = KIND_START; base = 6'd0;
            end else if (step < 6'd27) begin
               kind = KIND_WBIT; base = 6'd3;
            end else if (step < 6'd30) begin
               kind = KIND_ACKIN; base = 6'd27;
            end
         end
         FUNC_WRITE: begin
            if (step < 6'd24) begin
               kind = KIND_WBIT; base = 6'd0;
            end else if (step < 6'd27) begin
               kind = KIND_ACKIN; base = 6'd24;
            end else if (step < 6'd30 && end_flag) begin
               kind = KIND_STOP; base = 6'd27;
            end
         end
         FUNC_READ: begin
            if (step < 6'd1) begin
               kind = KIND_REL; base = 6'd0;
            end else if (step < 6'd25) begin
               kind = KIND_RBIT; base = 6'd1;
            end else if (step < 6'd28) begin
               kind = KIND_ACKOUT; base = 6'd25;
            end else if (step < 6'd31 && end_flag) begin
               kind = KIND_STOP; base = 6'd28;
            end
         end
         FUNC_STOP: begin
            if (step < 6'd3) begin
               kind = KIND_STOP; base = 6'd0;
            end
         end
         default: kind = KIND_END;
      endcase
      rel = step - base;
      prod = {4'd0, rel[4:0]} * 9'd11;
      quo = prod[8:5];
      rem = rel[4:0] - ({1'b0, quo} * 5'd3);
      ph.kind = kind;
      ph.sub = (kind == KIND_END) ? 2'd0 : rem[1:0];
      ph.idx = (kind == KIND_END) ? 3'd0 : quo[2:0];
      return ph;
   endfunction

endpackage

// File: src/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Every request transaction is one base tick: it carries the sampled SDA level
// and, while the sequencer is idle, an optional command (start with address,
// write byte, read byte, stop). Each tick returns exactly one response with the
// SCL/SDA drive levels, busy/done flags, the last acknowledge, the last read
// byte, the recent bit history and a rejected-command flag.
// Channels: req_* in, rsp_* out, both valid/ready; csr_* writes phase_ticks
// (index 0) and retry_limit (index 1); the user writes them only while idle,
// which the block itself does not enforce. A tick is written into the queue,
// then its response is registered. Throughput: one tick per cycle while
// rsp_tready stays high; a two-entry queue plus the response register decouple both sides.
// When rsp_tready is low the response register holds and the queue takes ticks
// until both of its entries are in use, then req_tready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue, clears the sequencer and
// loads phase_ticks = 100 and retry_limit = 3. No clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
   parameter int PHASE_COUNT_WIDTH = i2cms_pkg::PHASE_COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: address[6:0], read_not_write[7], write_data[15:8], sda_in[16], zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [i2cms_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // req_tuser: func[2:0]
   input  logic [i2cms_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   input  logic                                  req_tlast,
   // rsp_tdata: scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
   // acked[5], read_byte_out[13:6], recent_bits[21:14], cmd_rejected[22], zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [i2cms_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   i2cms_pkg::cfg_type  cfg_ff, cfg_in;
   logic                queue_full;
   logic                push;
   i2cms_pkg::item_type push_item;
   logic                pop;
   logic                pop_valid;
   i2cms_pkg::item_type pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            i2cms_pkg::CSR_PHASE_TICKS:
               cfg_in.phase_ticks = csr_wdata[i2cms_pkg::PHASE_TICKS_WIDTH-1:0];
            i2cms_pkg::CSR_RETRY_LIMIT:
               cfg_in.retry_limit = csr_wdata[i2cms_pkg::RETRY_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= i2cms_pkg::PHASE_TICKS_RESET;
         cfg_ff.retry_limit <= i2cms_pkg::RETRY_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cms_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   i2cms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   i2cms_seq #(
      .PHASE_COUNT_WIDTH (PHASE_COUNT_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (pop_valid),
      .q_item     (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: src/i2cms_front.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer front end
// Accepts request transactions and classifies the command they carry.
// ----------------------------------------------------------------------------
module i2cms_front (
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [i2cms_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic [i2cms_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   input  logic                                  req_tlast,
   input  logic                                  queue_full,
   output logic                                  push,
   output i2cms_pkg::item_type                   push_item
);

   i2cms_pkg::func_type func;
   logic [6:0]          address;
   logic                read_not_write;
   logic [7:0]          write_data;

   assign func           = i2cms_pkg::func_type'(req_tuser);
   assign address        = req_tdata[6:0];
   assign read_not_write = req_tdata[7];
   assign write_data     = req_tdata[15:8];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.cmd      = func;
      push_item.any_func = (func != i2cms_pkg::FUNC_NONE);
      push_item.has_cmd  = func inside {i2cms_pkg::FUNC_START, i2cms_pkg::FUNC_WRITE,
                                        i2cms_pkg::FUNC_READ, i2cms_pkg::FUNC_STOP};
      push_item.end_flag = req_tlast;
      push_item.sda      = req_tdata[16];
      case (func)
         i2cms_pkg::FUNC_START: push_item.load_byte = {address, read_not_write};
         i2cms_pkg::FUNC_WRITE: push_item.load_byte = write_data;
         default:               push_item.load_byte = 8'd0;
      endcase
   end

endmodule

// File: src/i2cms_queue.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer queue
// Short FIFO of classified items between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cms_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cms_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output i2cms_pkg::item_type pop_item
);

   localparam int Depth = i2cms_pkg::QUEUE_DEPTH;
   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   i2cms_pkg::item_type       entry_ff [Depth];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;

   assign full      = (count_ff == CountWidth'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/i2cms_seq.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer back end
// Steps through bus phases, one base tick per item, into a result register.
// ----------------------------------------------------------------------------
module i2cms_seq #(
   parameter int PHASE_COUNT_WIDTH = i2cms_pkg::PHASE_COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  i2cms_pkg::cfg_type                    cfg,
   input  logic                                  q_valid,
   input  i2cms_pkg::item_type                   q_item,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [i2cms_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int CmpWidth =
      ((PHASE_COUNT_WIDTH > i2cms_pkg::PHASE_TICKS_WIDTH) ?
       PHASE_COUNT_WIDTH : i2cms_pkg::PHASE_TICKS_WIDTH) + 1;

   i2cms_pkg::func_type            active_ff, active_in;
   logic [5:0]                     step_ff, step_in;
   logic [PHASE_COUNT_WIDTH-1:0]   tick_ff, tick_in;
   logic [7:0]                     sreg_ff, sreg_in;
   logic [2:0]                     attempt_ff, attempt_in;
   logic                           end_ff, end_in;
   logic                           ack_ff, ack_in;
   logic [7:0]                     recv_ff, recv_in;
   logic [7:0]                     hist_ff, hist_in;
   logic                           held_ff, held_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   i2cms_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                           idle;
   logic                           load;
   i2cms_pkg::func_type            eff_active;
   logic [5:0]                     eff_step;
   logic [PHASE_COUNT_WIDTH-1:0]   eff_tick;
   logic [2:0]                     eff_attempt;
   logic                           eff_end;
   logic [7:0]                     eff_shift;
   i2cms_pkg::phase_type           ph;
   i2cms_pkg::phase_type           nph;
   logic [5:0]                     step_next;
   logic                           cur_bit;
   logic [i2cms_pkg::PHASE_TICKS_WIDTH-1:0] pt;
   logic [i2cms_pkg::RETRY_WIDTH-1:0]       lim;
   logic                           fire;
   logic                           retry;
   logic                           scl_o, sda_o, drv_o;

   assign pop        = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign idle = (active_ff == i2cms_pkg::FUNC_NONE);
   assign load = idle && q_item.has_cmd;

   assign eff_active  = load ? q_item.cmd : active_ff;
   assign eff_step    = load ? 6'd0 : step_ff;
   assign eff_tick    = load ? '0 : tick_ff;
   assign eff_attempt = load ? 3'd0 : attempt_ff;
   assign eff_end     = load ? q_item.end_flag : end_ff;
   assign eff_shift   = load ? q_item.load_byte : sreg_ff;

   assign ph        = i2cms_pkg::decode(eff_active, eff_step, eff_end);
   assign step_next = eff_step + 6'd1;
   assign nph       = i2cms_pkg::decode(eff_active, step_next, eff_end);
   assign cur_bit   = eff_shift[3'd7 - ph.idx];

   // A zero in either register acts as one.
   assign pt  = (cfg.phase_ticks == '0) ? i2cms_pkg::PHASE_TICKS_WIDTH'(1) : cfg.phase_ticks;
   assign lim = (cfg.retry_limit == '0) ? i2cms_pkg::RETRY_WIDTH'(1) : cfg.retry_limit;

   assign fire  = (CmpWidth'(eff_tick) + CmpWidth'(1)) >= CmpWidth'(pt);
   assign retry = (ph.kind == i2cms_pkg::KIND_ACKIN) && (ph.sub == 2'd2) && !ack_ff &&
                  (({1'b0, eff_attempt} + 4'd1) < {1'b0, lim});

   // Bus levels for this tick.
   always_comb begin
      scl_o = 1'b1;
      sda_o = 1'b1;
      drv_o = 1'b1;
      if (eff_active == i2cms_pkg::FUNC_NONE) begin
         if (held_ff) begin
            scl_o = 1'b0;
            sda_o = 1'b0;
         end
      end else begin
         scl_o = (ph.sub == 2'd1);
         case (ph.kind)
            i2cms_pkg::KIND_START: begin
               sda_o = (ph.sub == 2'd0);
               scl_o = (ph.sub != 2'd2);
            end
            i2cms_pkg::KIND_STOP: begin
               sda_o = (ph.sub == 2'd2);
               scl_o = (ph.sub != 2'd0);
            end
            i2cms_pkg::KIND_WBIT: sda_o = cur_bit;
            i2cms_pkg::KIND_ACKIN: begin
               sda_o = 1'b0;
               drv_o = (ph.sub == 2'd2);
            end
            i2cms_pkg::KIND_REL, i2cms_pkg::KIND_RBIT: begin
               sda_o = 1'b0;
               drv_o = 1'b0;
            end
            i2cms_pkg::KIND_ACKOUT: sda_o = eff_end;
            default: sda_o = 1'b0;
         endcase
      end
   end

   // Sequencer state update for the popped tick.
   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      tick_in      = tick_ff;
      sreg_in      = sreg_ff;
      attempt_in   = attempt_ff;
      end_in       = end_ff;
      ack_in       = ack_ff;
      recv_in      = recv_ff;
      hist_in      = hist_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         active_in  = eff_active;
         step_in    = eff_step;
         tick_in    = eff_tick;
         sreg_in    = eff_shift;
         attempt_in = eff_attempt;
         end_in     = eff_end;

         rsp_data_in.pad          = 1'b0;
         rsp_data_in.done_res     = 1'b0;
         rsp_data_in.busy_res     = (eff_active != i2cms_pkg::FUNC_NONE);
         rsp_data_in.cmd_rejected = idle ? (q_item.any_func && !q_item.has_cmd)
                                         : q_item.any_func;

         if (eff_active != i2cms_pkg::FUNC_NONE) begin
            if (fire) begin
               tick_in = '0;
               if (ph.kind == i2cms_pkg::KIND_WBIT && ph.sub == 2'd2) begin
                  hist_in = {hist_ff[6:0], cur_bit};
               end
               if (ph.kind == i2cms_pkg::KIND_RBIT && ph.sub == 2'd1) begin
                  sreg_in = {eff_shift[6:0], q_item.sda};
                  hist_in = {hist_ff[6:0], q_item.sda};
                  if (ph.idx == 3'd7) begin
                     recv_in = {eff_shift[6:0], q_item.sda};
                  end
               end
               if (ph.kind == i2cms_pkg::KIND_ACKIN && ph.sub == 2'd1) begin
                  ack_in = !q_item.sda;
               end
               if (retry) begin
                  attempt_in = eff_attempt + 3'd1;
                  step_in    = 6'd0;
               end else begin
                  step_in = step_next;
                  if (nph.kind == i2cms_pkg::KIND_END) begin
                     rsp_data_in.done_res = 1'b1;
                     held_in = !((eff_active == i2cms_pkg::FUNC_STOP) ||
                                 ((eff_active inside {i2cms_pkg::FUNC_WRITE,
                                                      i2cms_pkg::FUNC_READ}) && eff_end));
                     active_in  = i2cms_pkg::FUNC_NONE;
                     step_in    = 6'd0;
                     attempt_in = 3'd0;
                  end
               end
            end else begin
               tick_in = eff_tick + 1'b1;
            end
         end

         rsp_valid_in              = 1'b1;
         rsp_data_in.scl_level     = scl_o;
         rsp_data_in.sda_level     = sda_o;
         rsp_data_in.sda_drive     = drv_o;
         rsp_data_in.acked         = ack_in;
         rsp_data_in.read_byte_out = recv_in;
         rsp_data_in.recent_bits   = hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= i2cms_pkg::FUNC_NONE;
         step_ff      <= '0;
         tick_ff      <= '0;
         sreg_ff      <= '0;
         attempt_ff   <= '0;
         end_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         recv_ff      <= '0;
         hist_ff      <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         tick_ff      <= tick_in;
         sreg_ff      <= sreg_in;
         attempt_ff   <= attempt_in;
         end_ff       <= end_in;
         ack_ff       <= ack_in;
         recv_ff      <= recv_in;
         hist_ff      <= hist_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // An idle sequencer always sits at the first step with a cleared tick count.
   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      (active_ff == i2cms_pkg::FUNC_NONE) |-> (step_ff == 6'd0 && attempt_ff == 3'd0 &&
                                               tick_ff == '0))
      else $error("idle sequencer holds stale step, attempt or tick state");

   // The longest command is a read with a stop, which never parks past step 30.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff != i2cms_pkg::FUNC_NONE) |-> (step_ff <= 6'd30))
      else $error("phase step ran past the end of its command");

   // Retries stop one short of the attempt limit.
   a_attempt_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff != i2cms_pkg::FUNC_NONE) |-> ({1'b0, attempt_ff} < {1'b0, lim}))
      else $error("attempt count reached the retry limit");

   // A command completes only on a tick that reports it busy.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> rsp_data_ff.busy_res)
      else $error("done reported on a tick without a command");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Sends one base tick per request transaction and checks every response
// against a cycle-true predictor of the sequencer kept in the testbench.
// Directed tests cover idle outputs, start/write/read/stop flows, NACK
// retries, busy rejects and the timing register extremes. Random traffic then
// runs mostly well-formed bus transfers with random content and noise, under three
// back-pressure settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [i2cms_pkg::REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [i2cms_pkg::REQ_TUSER_WIDTH-1:0] req_tuser  = '0;
   logic                                  req_tlast  = 1'b0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [i2cms_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                                  csr_wr_en  = 1'b0;
   logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [i2cms_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   i2c_master_bit_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted sequencer state and register copies.
   logic [15:0]         cfg_phase_ticks;
   logic [2:0]          cfg_retry_limit;
   int unsigned         seq_ticks;
   logic [5:0]          seq_step;
   i2cms_pkg::func_type seq_cmd;
   logic [7:0]          seq_shift;
   logic [2:0]          seq_tries;
   logic                seq_end;
   logic                seq_ack;
   logic [7:0]          seq_rx_byte;
   logic [7:0]          seq_history;
   logic                seq_bus_held;

   i2cms_pkg::rsp_type  expected_bus_rsp[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned ticks_sent = 0;
   int unsigned rsp_checked = 0;
   int unsigned commands_issued = 0;
   int unsigned csr_writes = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   i2cms_pkg::rsp_type got_rsp;
   i2cms_pkg::rsp_type want_rsp;

   function automatic i2cms_pkg::phase_type bus_phase(i2cms_pkg::func_type cmd,
                                                      logic [5:0] step, logic end_f);
      i2cms_pkg::phase_type ph;
      int unsigned          base;
      int unsigned          rel;
      ph.kind = i2cms_pkg::KIND_END;
      base = 0;
      case (cmd)
         i2cms_pkg::FUNC_START: begin
            if (step < 3) begin
               ph.kind = i2cms_pkg::KIND_START;
            end else if (step < 27) begin
               ph.kind = i2cms_pkg::KIND_WBIT; base = 3;
            end else if (step < 30) begin
               ph.kind = i2cms_pkg::KIND_ACKIN; base = 27;
            end
         end
         i2cms_pkg::FUNC_WRITE: begin
            if (step < 24) begin
               ph.kind = i2cms_pkg::KIND_WBIT;
            end else if (step < 27) begin
               ph.kind = i2cms_pkg::KIND_ACKIN; base = 24;
            end else if (step < 30 && end_f) begin
               ph.kind = i2cms_pkg::KIND_STOP; base = 27;
            end
         end
         i2cms_pkg::FUNC_READ: begin
            if (step < 1) begin
               ph.kind = i2cms_pkg::KIND_REL;
            end else if (step < 25) begin
               ph.kind = i2cms_pkg::KIND_RBIT; base = 1;
            end else if (step < 28) begin
               ph.kind = i2cms_pkg::KIND_ACKOUT; base = 25;
            end else if (step < 31 && end_f) begin
               ph.kind = i2cms_pkg::KIND_STOP; base = 28;
            end
         end
         i2cms_pkg::FUNC_STOP: begin
            if (step < 3) ph.kind = i2cms_pkg::KIND_STOP;
         end
         default: ph.kind = i2cms_pkg::KIND_END;
      endcase
      rel = step - base;
      if (ph.kind == i2cms_pkg::KIND_END) begin
         ph.sub = 2'd0;
         ph.idx = 3'd0;
      end else begin
         ph.sub = 2'(rel % 3);
         ph.idx = 3'((rel / 3) % 8);
      end
      return ph;
   endfunction

   task automatic reset_sequencer_model();
      cfg_phase_ticks = i2cms_pkg::PHASE_TICKS_RESET;
      cfg_retry_limit = i2cms_pkg::RETRY_LIMIT_RESET;
      seq_ticks = 0;
      seq_step = '0;
      seq_cmd = i2cms_pkg::FUNC_NONE;
      seq_shift = '0;
      seq_tries = '0;
      seq_end = 1'b0;
      seq_ack = 1'b0;
      seq_rx_byte = '0;
      seq_history = '0;
      seq_bus_held = 1'b0;
   endtask

   // Advances the predicted sequencer by one base tick and queues the
   // bus state it should report for that tick.
   task automatic step_sequencer(input logic [2:0] func, input logic [6:0] addr,
                                 input logic rnw, input logic [7:0] wdata,
                                 input logic last, input logic sda);
      i2cms_pkg::rsp_type   r;
      i2cms_pkg::phase_type ph;
      logic                 bit_v;
      int unsigned          period;
      int unsigned          lim;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      r.sda_drive = 1'b1;
      if (seq_cmd == i2cms_pkg::FUNC_NONE) begin
         if (func >= i2cms_pkg::FUNC_START && func <= i2cms_pkg::FUNC_STOP) begin
            seq_cmd = i2cms_pkg::func_type'(func);
            seq_step = '0;
            seq_ticks = 0;
            seq_tries = '0;
            seq_end = last;
            if (func == i2cms_pkg::FUNC_START) seq_shift = {addr, rnw};
            else if (func == i2cms_pkg::FUNC_WRITE) seq_shift = wdata;
            else seq_shift = '0;
         end else if (func != i2cms_pkg::FUNC_NONE) begin
            r.cmd_rejected = 1'b1;
         end
      end else if (func != i2cms_pkg::FUNC_NONE) begin
         r.cmd_rejected = 1'b1;
      end

      if (seq_cmd == i2cms_pkg::FUNC_NONE) begin
         if (seq_bus_held) begin
            r.scl_level = 1'b0;
            r.sda_level = 1'b0;
         end
      end else begin
         r.busy_res = 1'b1;
         ph = bus_phase(seq_cmd, seq_step, seq_end);
         bit_v = seq_shift[7 - ph.idx];
         r.scl_level = (ph.sub == 2'd1);
         case (ph.kind)
            i2cms_pkg::KIND_START: begin
               r.sda_level = (ph.sub == 2'd0);
               r.scl_level = (ph.sub != 2'd2);
            end
            i2cms_pkg::KIND_STOP: begin
               r.sda_level = (ph.sub == 2'd2);
               r.scl_level = (ph.sub != 2'd0);
            end
            i2cms_pkg::KIND_WBIT: r.sda_level = bit_v;
            i2cms_pkg::KIND_ACKIN: begin
               r.sda_level = 1'b0;
               r.sda_drive = (ph.sub == 2'd2);
            end
            i2cms_pkg::KIND_REL, i2cms_pkg::KIND_RBIT: begin
               r.sda_level = 1'b0;
               r.sda_drive = 1'b0;
            end
            i2cms_pkg::KIND_ACKOUT: r.sda_level = seq_end;
            default: r.sda_level = 1'b0;
         endcase

         period = (cfg_phase_ticks == 0) ? 1 : cfg_phase_ticks;
         if (seq_ticks + 1 >= period) begin
            seq_ticks = 0;
            lim = (cfg_retry_limit == 0) ? 1 : cfg_retry_limit;
            if (ph.kind == i2cms_pkg::KIND_WBIT && ph.sub == 2'd2)
               seq_history = {seq_history[6:0], bit_v};
            if (ph.kind == i2cms_pkg::KIND_RBIT && ph.sub == 2'd1) begin
               seq_shift = {seq_shift[6:0], sda};
               seq_history = {seq_history[6:0], sda};
               if (ph.idx == 3'd7) seq_rx_byte = seq_shift;
            end
            if (ph.kind == i2cms_pkg::KIND_ACKIN && ph.sub == 2'd1) seq_ack = ~sda;
            if (ph.kind == i2cms_pkg::KIND_ACKIN && ph.sub == 2'd2 && !seq_ack &&
                seq_tries + 1 < lim) begin
               // NACK with attempts left: the address or byte goes out again.
               seq_tries = seq_tries + 3'd1;
               seq_step = '0;
            end else begin
               seq_step = seq_step + 6'd1;
               ph = bus_phase(seq_cmd, seq_step, seq_end);
               if (ph.kind == i2cms_pkg::KIND_END) begin
                  r.done_res = 1'b1;
                  seq_bus_held = !(seq_cmd == i2cms_pkg::FUNC_STOP ||
                                   ((seq_cmd == i2cms_pkg::FUNC_WRITE ||
                                     seq_cmd == i2cms_pkg::FUNC_READ) && seq_end));
                  seq_cmd = i2cms_pkg::FUNC_NONE;
                  seq_step = '0;
                  seq_tries = '0;
               end
            end
         end else begin
            seq_ticks = seq_ticks + 1;
         end
      end
      r.acked = seq_ack;
      r.read_byte_out = seq_rx_byte;
      r.recent_bits = seq_history;
      expected_bus_rsp.push_back(r);
   endtask

   // Starts at a falling edge, ends at the rising edge that took the tick.
   task automatic send_tick(input logic [2:0] func, input logic [6:0] addr, input logic rnw,
                            input logic [7:0] wdata, input logic last, input logic sda);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= {7'd0, sda, wdata, rnw, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_sequencer(func, addr, rnw, wdata, last, sda);
      ticks_sent++;
   endtask

   function automatic logic sda_level_for(int unsigned high_pct);
      return ($urandom_range(99) < high_pct);
   endfunction

   // Issues one command and keeps ticking until the sequencer is idle again.
   // noise_pct is the share of ticks that carry a command while busy.
   task automatic run_command(input logic [2:0] func, input logic [6:0] addr, input logic rnw,
                              input logic [7:0] wdata, input logic last,
                              input int unsigned high_pct, input int unsigned noise_pct);
      logic [2:0] busy_func;
      commands_issued++;
      send_tick(func, addr, rnw, wdata, last, sda_level_for(high_pct));
      while (seq_cmd != i2cms_pkg::FUNC_NONE) begin
         busy_func = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(1, 7))
                                                       : i2cms_pkg::FUNC_NONE;
         send_tick(busy_func, 7'($urandom_range(127)), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 1'($urandom_range(1)),
                   sda_level_for(high_pct));
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bus_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [i2cms_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [i2cms_pkg::CSR_DATA_WIDTH-1:0] value);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == i2cms_pkg::CSR_PHASE_TICKS) cfg_phase_ticks = value;
      else cfg_retry_limit = value[2:0];
      csr_writes++;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("tb: mismatch in response %0d, %s: expected %0h, got %0h",
                     rsp_checked, name, want, got);
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_tdata;
         if (expected_bus_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: response %0d arrived with none expected: %h",
                        rsp_checked, rsp_tdata);
         end else begin
            want_rsp = expected_bus_rsp.pop_front();
            compare_field("scl_level", int'(want_rsp.scl_level), int'(got_rsp.scl_level));
            compare_field("sda_level", int'(want_rsp.sda_level), int'(got_rsp.sda_level));
            compare_field("sda_drive", int'(want_rsp.sda_drive), int'(got_rsp.sda_drive));
            compare_field("busy_res", int'(want_rsp.busy_res), int'(got_rsp.busy_res));
            compare_field("done_res", int'(want_rsp.done_res), int'(got_rsp.done_res));
            compare_field("acked", int'(want_rsp.acked), int'(got_rsp.acked));
            compare_field("read_byte_out", int'(want_rsp.read_byte_out),
                          int'(got_rsp.read_byte_out));
            compare_field("recent_bits", int'(want_rsp.recent_bits),
                          int'(got_rsp.recent_bits));
            compare_field("cmd_rejected", int'(want_rsp.cmd_rejected),
                          int'(got_rsp.cmd_rejected));
         end
         rsp_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Idle outputs after reset, undefined codes on an idle sequencer, and a
   // stop on a free bus at the reset phase length.
   task automatic test_idle_outputs();
      send_tick(i2cms_pkg::FUNC_NONE, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      send_tick(i2cms_pkg::FUNC_NONE, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1);
      send_tick(3'd5, 7'h2A, 1'b0, 8'h55, 1'b0, 1'b1);
      send_tick(3'd6, 7'h55, 1'b1, 8'hAA, 1'b1, 1'b0);
      send_tick(3'd7, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 50, 0);
   endtask

   task automatic test_write_transfer();
      write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'd1);
      run_command(i2cms_pkg::FUNC_START, 7'h7F, 1'b0, 8'h00, 1'b0, 0, 0);
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0, 0, 0);
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'h00, 1'b1, 0, 0);
   endtask

   task automatic test_read_transfer();
      run_command(i2cms_pkg::FUNC_START, 7'h00, 1'b1, 8'h00, 1'b0, 0, 0);
      run_command(i2cms_pkg::FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b0, 100, 0);
      run_command(i2cms_pkg::FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b0, 0, 0);
      run_command(i2cms_pkg::FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b0, 50, 0);
      // The last read is answered with NACK and closed with a stop.
      run_command(i2cms_pkg::FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b1, 50, 0);
   endtask

   task automatic test_nack_retries();
      write_csr(i2cms_pkg::CSR_RETRY_LIMIT, 16'd7);
      run_command(i2cms_pkg::FUNC_START, 7'h3C, 1'b0, 8'h00, 1'b0, 100, 0);
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'hC3, 1'b0, 100, 0);
      // A limit of zero behaves as a single attempt; upper data bits are dropped.
      write_csr(i2cms_pkg::CSR_RETRY_LIMIT, 16'hABC8);
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'h5A, 1'b1, 100, 0);
      write_csr(i2cms_pkg::CSR_RETRY_LIMIT, 16'd1);
      run_command(i2cms_pkg::FUNC_START, 7'h41, 1'b0, 8'h00, 1'b0, 100, 0);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 100, 0);
   endtask

   task automatic test_busy_rejects();
      write_csr(i2cms_pkg::CSR_RETRY_LIMIT, 16'd3);
      run_command(i2cms_pkg::FUNC_START, 7'h55, 1'b0, 8'hA5, 1'b0, 20, 100);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 20, 100);
   endtask

   // Commands outside a framed transfer are carried out as given.
   task automatic test_bare_commands();
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'h96, 1'b0, 30, 0);
      run_command(i2cms_pkg::FUNC_READ, 7'h00, 1'b0, 8'h00, 1'b0, 50, 0);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 50, 0);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b1, 50, 0);
   endtask

   task automatic test_phase_extremes();
      // A phase length of zero counts as one tick.
      write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'd0);
      run_command(i2cms_pkg::FUNC_WRITE, 7'h00, 1'b0, 8'h3E, 1'b1, 30, 0);
      write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'd9);
      run_command(i2cms_pkg::FUNC_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 50, 0);
      write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'hFFFF);
      send_tick(i2cms_pkg::FUNC_NONE, 7'h00, 1'b0, 8'h00, 1'b0, 1'b1);
      send_tick(3'd7, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      send_tick(i2cms_pkg::FUNC_NONE, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'd2);
   endtask

   task automatic pick_random_config();
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0) write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'd0);
      else if (roll == 1) write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'($urandom_range(4, 12)));
      else write_csr(i2cms_pkg::CSR_PHASE_TICKS, 16'($urandom_range(1, 3)));
      write_csr(i2cms_pkg::CSR_RETRY_LIMIT, 16'($urandom_range(0, 7)));
   endtask

   // Mostly framed transfers (start, bytes, stop or last byte, repeated
   // starts) with random content; the rest is lone commands and bad codes.
   task automatic test_random_traffic(input int unsigned tick_budget,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct);
      int unsigned stop_at;
      int unsigned transfer_no;
      int unsigned high_pct;
      int unsigned roll;
      int          bytes_left;
      bit          in_transfer;
      bit          reading;
      logic        last;
      logic [2:0]  func;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = ticks_sent + tick_budget;
      transfer_no = 0;
      high_pct = 10;
      bytes_left = 0;
      in_transfer = 1'b0;
      reading = 1'b0;
      while (ticks_sent < stop_at) begin
         if (!in_transfer) begin
            if (transfer_no % 5 == 0) pick_random_config();
            transfer_no++;
            roll = $urandom_range(9);
            high_pct = (roll < 6) ? 5 : (roll < 8) ? 50 : 95;
            if ($urandom_range(99) < 85) begin
               reading = 1'($urandom_range(1));
               bytes_left = $urandom_range(1, 4);
               in_transfer = 1'b1;
               run_command(i2cms_pkg::FUNC_START, 7'($urandom_range(127)), reading,
                           8'($urandom_range(255)), 1'($urandom_range(1)), high_pct, 4);
            end else begin
               run_command(3'($urandom_range(2, 7)), 7'($urandom_range(127)),
                           1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)), high_pct, 4);
            end
         end else if (bytes_left > 0) begin
            last = (bytes_left == 1) && ($urandom_range(99) < 70);
            func = reading ? i2cms_pkg::FUNC_READ : i2cms_pkg::FUNC_WRITE;
            if ($urandom_range(9) == 0)
               func = reading ? i2cms_pkg::FUNC_WRITE : i2cms_pkg::FUNC_READ;
            run_command(func, 7'($urandom_range(127)), 1'($urandom_range(1)),
                        8'($urandom_range(255)), last, high_pct, 4);
            bytes_left--;
            if (last) in_transfer = 1'b0;
         end else if ($urandom_range(99) < 25) begin
            reading = 1'($urandom_range(1));
            bytes_left = $urandom_range(1, 3);
            run_command(i2cms_pkg::FUNC_START, 7'($urandom_range(127)), reading,
                        8'($urandom_range(255)), 1'($urandom_range(1)), high_pct, 4);
         end else begin
            run_command(i2cms_pkg::FUNC_STOP, 7'($urandom_range(127)),
                        1'($urandom_range(1)), 8'($urandom_range(255)),
                        1'($urandom_range(1)), high_pct, 4);
            in_transfer = 1'b0;
         end
         repeat ($urandom_range(0, 2)) begin
            func = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                            : i2cms_pkg::FUNC_NONE;
            send_tick(func, 7'($urandom_range(127)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset_sequencer_model();
      send_idle_pct = 28;
      recv_idle_pct = 77;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_outputs();
      test_write_transfer();
      test_read_transfer();
      test_nack_retries();
      test_busy_rejects();
      test_bare_commands();
      test_phase_extremes();

      // Hold the sender until the response side has fully caught up.
      drain_responses();

      test_random_traffic(220, 28, 77);
      test_random_traffic(220, 77, 28);
      test_random_traffic(220, 0, 0);

      drain_responses();
      repeat (16) @(posedge clock);

      $display("tb: %0d ticks sent, %0d commands issued, %0d register writes",
               ticks_sent, commands_issued, csr_writes);
      $display("tb: %0d responses checked, %0d mismatches", rsp_checked, mismatch_count);
      if (mismatch_count == 0 && expected_bus_rsp.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
